### rtl/core/alc_pkg.sv
// Shared types and codes of the analog limit alarm classifier.
// Used by the register block, the classifier, the record emitter and the top level.
// No dependencies.
package alc_pkg;

  // register indexes (byte address = index * 4)
  localparam logic [2:0] REG_SCAN_ENABLE       = 3'd0;
  localparam logic [2:0] REG_DEAD_BAND         = 3'd1;
  localparam logic [2:0] REG_HIGH_LIMIT        = 3'd2;
  localparam logic [2:0] REG_HIGH_HIGH_LIMIT   = 3'd3;
  localparam logic [2:0] REG_LOW_LIMIT         = 3'd4;
  localparam logic [2:0] REG_LOW_LOW_LIMIT     = 3'd5;
  localparam logic [2:0] REG_HIGH_RETURN_LIMIT = 3'd6;
  localparam logic [2:0] REG_LOW_RETURN_LIMIT  = 3'd7;

  localparam int unsigned ADDR_W = 5;

  // limit state codes
  localparam logic [2:0] ST_NORMAL     = 3'd0;
  localparam logic [2:0] ST_HI_WARN    = 3'd1;
  localparam logic [2:0] ST_HI_ALARM   = 3'd2;
  localparam logic [2:0] ST_LO_WARN    = 3'd3;
  localparam logic [2:0] ST_LO_ALARM   = 3'd4;
  localparam logic [2:0] ST_HI_RECOVER = 3'd5;
  localparam logic [2:0] ST_LO_RECOVER = 3'd6;

  // record kinds
  localparam logic KIND_LINE_FAIL = 1'b0;
  localparam logic KIND_LIMIT     = 1'b1;

  // record mask bits, in emission order
  localparam int unsigned REC_LINE_FAIL = 0;
  localparam int unsigned REC_RECOVER   = 1;
  localparam int unsigned REC_HI_WARN   = 2;
  localparam int unsigned REC_HI_ALARM  = 3;
  localparam int unsigned REC_LO_WARN   = 4;
  localparam int unsigned REC_LO_ALARM  = 5;
  localparam int unsigned REC_N         = 6;

  typedef logic [REC_N-1:0] rec_mask_t;

  typedef struct packed {
    logic               scan_enable;
    logic [30:0]        dead_band;
    logic signed [31:0] high_limit;
    logic signed [31:0] high_high_limit;
    logic signed [31:0] low_limit;
    logic signed [31:0] low_low_limit;
    logic signed [31:0] high_return_limit;
    logic signed [31:0] low_return_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        point_tag;
    logic signed [31:0] sample_value;
    logic               channel_fault;
    logic signed [31:0] last_value;
    logic [2:0]         prior_limit_state;
    logic               prior_line_fail;
    logic [31:0]        stored_data;
  } item_t;

endpackage

### rtl/core/analog_limit_alarm_classifier_core.sv
// Analog limit alarm classifier, top level: register block, input register, classifier, record emitter.
// Path: a word accepted into the input register moves on to the emitter's result register,
// whose records drive the result ports. Throughput: one word per cycle while words give at
// most one record; a word with up to four records holds the emitter until its last one is out.
// busy rises only while the input register waits on the emitter; the receiver cannot stall.
// Synchronous active-high reset zeroes the configuration and the valid flags.
module analog_limit_alarm_classifier_core
  import alc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        point_tag,
  input  logic signed [31:0] sample_value,
  input  logic               channel_fault,
  input  logic signed [31:0] last_value,
  input  logic [2:0]         prior_limit_state,
  input  logic               prior_line_fail,
  input  logic [31:0]        stored_data,
  // result side
  output logic               alarm_valid,
  output logic [15:0]        alarm_point,
  output logic               alarm_kind,
  output logic [2:0]         new_limit_state,
  output logic               new_line_fail,
  output logic [31:0]        record_data,
  output logic               last_of_run
);

  cfg_t       cfg;
  item_t      item;
  logic       in_valid;
  logic       accept;
  logic       move;
  logic       emit_free;
  rec_mask_t  mask;
  logic [2:0] recover_code;

  alc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign move   = in_valid && emit_free;
  assign busy   = in_valid && !emit_free;
  assign accept = start && !busy;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (move) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.point_tag         <= point_tag;
      item.sample_value      <= sample_value;
      item.channel_fault     <= channel_fault;
      item.last_value        <= last_value;
      item.prior_limit_state <= prior_limit_state;
      item.prior_line_fail   <= prior_line_fail;
      item.stored_data       <= stored_data;
    end
  end

  alc_classify u_classify (
    .cfg          (cfg),
    .item         (item),
    .mask         (mask),
    .recover_code (recover_code)
  );

  alc_emit u_emit (
    .clk             (clk),
    .rst             (rst),
    .load            (move),
    .item_in         (item),
    .mask_in         (mask),
    .recover_in      (recover_code),
    .free            (emit_free),
    .alarm_valid     (alarm_valid),
    .alarm_point     (alarm_point),
    .alarm_kind      (alarm_kind),
    .new_limit_state (new_limit_state),
    .new_line_fail   (new_line_fail),
    .record_data     (record_data),
    .last_of_run     (last_of_run)
  );

endmodule

### rtl/core/alc_cfg_regs.sv
// Configuration register file with an APB-style access port.
// Depends on alc_pkg for register indexes and the cfg_t bundle.
module alc_cfg_regs
  import alc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;

  // write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SCAN_ENABLE:       cfg.scan_enable       <= pwdata[0];
        REG_DEAD_BAND:         cfg.dead_band         <= pwdata[30:0];
        REG_HIGH_LIMIT:        cfg.high_limit        <= pwdata;
        REG_HIGH_HIGH_LIMIT:   cfg.high_high_limit   <= pwdata;
        REG_LOW_LIMIT:         cfg.low_limit         <= pwdata;
        REG_LOW_LOW_LIMIT:     cfg.low_low_limit     <= pwdata;
        REG_HIGH_RETURN_LIMIT: cfg.high_return_limit <= pwdata;
        REG_LOW_RETURN_LIMIT:  cfg.low_return_limit  <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_SCAN_ENABLE:       prdata = {31'd0, cfg.scan_enable};
      REG_DEAD_BAND:         prdata = {1'b0, cfg.dead_band};
      REG_HIGH_LIMIT:        prdata = cfg.high_limit;
      REG_HIGH_HIGH_LIMIT:   prdata = cfg.high_high_limit;
      REG_LOW_LIMIT:         prdata = cfg.low_limit;
      REG_LOW_LOW_LIMIT:     prdata = cfg.low_low_limit;
      REG_HIGH_RETURN_LIMIT: prdata = cfg.high_return_limit;
      REG_LOW_RETURN_LIMIT:  prdata = cfg.low_return_limit;
      default:               prdata = 32'd0;
    endcase
  end

endmodule

### rtl/core/alc_classify.sv
// Classifies one registered word against the limits and yields its record mask.
// Depends on alc_pkg for the item, configuration and mask types.
module alc_classify
  import alc_pkg::*;
(
  input  cfg_t      cfg,
  input  item_t     item,
  output rec_mask_t mask,
  output logic [2:0] recover_code
);

  logic signed [32:0] diff;
  logic signed [32:0] db_pos;
  logic signed [32:0] db_neg;
  logic               pass;
  logic               hi_prior;
  logic               lo_prior;
  logic               in_range;
  logic               in_ret;
  logic               recover;
  logic signed [31:0] v;

  assign v = item.sample_value;

  // deadband test on the exact 33-bit difference
  assign diff   = 33'(v) - 33'(item.last_value);
  assign db_pos = $signed({2'b00, cfg.dead_band});
  assign db_neg = -db_pos;
  assign pass   = (cfg.dead_band != '0) ? ((diff >= db_pos) || (diff <= db_neg))
                                        : (diff != '0);

  assign hi_prior = (item.prior_limit_state == ST_HI_WARN) ||
                    (item.prior_limit_state == ST_HI_ALARM);
  assign lo_prior = (item.prior_limit_state == ST_LO_WARN) ||
                    (item.prior_limit_state == ST_LO_ALARM);

  // recovery into the normal range through the return band
  assign in_range = (v >= cfg.low_limit) && (v <= cfg.high_limit);
  assign in_ret   = (v >= cfg.low_return_limit) && (v <= cfg.high_return_limit);
  assign recover  = in_range && (hi_prior || lo_prior) &&
                    (in_ret || (hi_prior && (v < cfg.low_return_limit)) ||
                     (lo_prior && (v > cfg.high_return_limit)));
  assign recover_code = hi_prior ? ST_HI_RECOVER : ST_LO_RECOVER;

  // build the mask; limit records only on a good channel past the deadband
  always_comb begin
    mask = '0;
    if (cfg.scan_enable) begin
      mask[REC_LINE_FAIL] = item.channel_fault != item.prior_line_fail;
      if (!item.channel_fault && pass) begin
        mask[REC_RECOVER]  = recover;
        mask[REC_HI_WARN]  = (v > cfg.high_limit) && (v <= cfg.high_high_limit) &&
                             (item.prior_limit_state != ST_HI_WARN);
        mask[REC_HI_ALARM] = (v >= cfg.high_high_limit) &&
                             (item.prior_limit_state != ST_HI_ALARM);
        mask[REC_LO_WARN]  = (v < cfg.low_limit) && (v >= cfg.low_low_limit) &&
                             (item.prior_limit_state != ST_LO_WARN);
        mask[REC_LO_ALARM] = (v < cfg.low_low_limit) &&
                             (item.prior_limit_state != ST_LO_ALARM);
      end
    end
  end

endmodule

### rtl/core/alc_emit.sv
// Result register and record sequencer: holds one classified word and
// issues its records one per cycle, lowest mask bit first.
// Depends on alc_pkg for the item and mask types and the state codes.
module alc_emit
  import alc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  item_t       item_in,
  input  rec_mask_t   mask_in,
  input  logic [2:0]  recover_in,
  output logic        free,
  output logic        alarm_valid,
  output logic [15:0] alarm_point,
  output logic        alarm_kind,
  output logic [2:0]  new_limit_state,
  output logic        new_line_fail,
  output logic [31:0] record_data,
  output logic        last_of_run
);

  rec_mask_t  mask;
  rec_mask_t  low_bit;
  rec_mask_t  rest;
  item_t      item;
  logic [2:0] recover_code;

  // lowest pending record and what remains after it
  assign low_bit = mask & (~mask + rec_mask_t'(1));
  assign rest    = mask & ~low_bit;
  assign free    = (rest == '0);

  // advance the mask, or take a new word when the last record goes out or none is pending
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= mask_in;
    end else begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item         <= item_in;
      recover_code <= recover_in;
    end
  end

  assign alarm_valid = (mask != '0);
  assign alarm_point = item.point_tag;
  assign record_data = item.stored_data;
  assign last_of_run = alarm_valid && free;

  // record fields for the selected bit
  always_comb begin
    alarm_kind      = KIND_LIMIT;
    new_line_fail   = item.prior_line_fail;
    new_limit_state = ST_NORMAL;
    case (1'b1)
      low_bit[REC_LINE_FAIL]: begin
        alarm_kind      = KIND_LINE_FAIL;
        new_line_fail   = item.channel_fault;
        new_limit_state = item.prior_limit_state;
      end
      low_bit[REC_RECOVER]:  new_limit_state = recover_code;
      low_bit[REC_HI_WARN]:  new_limit_state = ST_HI_WARN;
      low_bit[REC_HI_ALARM]: new_limit_state = ST_HI_ALARM;
      low_bit[REC_LO_WARN]:  new_limit_state = ST_LO_WARN;
      low_bit[REC_LO_ALARM]: new_limit_state = ST_LO_ALARM;
      default: ;
    endcase
  end

endmodule

### tb/alarm_record_checker.sv
// Scoreboard for the analog limit alarm classifier: shadows the register file from the
// configuration port, predicts the alarm records of every accepted word and checks them.
// Depends on alc_pkg for register indexes, state codes, record kinds and the word type.
`timescale 1ns / 100ps

module alarm_record_checker
  import alc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic [15:0]        point_tag,
  input  logic signed [31:0] sample_value,
  input  logic               channel_fault,
  input  logic signed [31:0] last_value,
  input  logic [2:0]         prior_limit_state,
  input  logic               prior_line_fail,
  input  logic [31:0]        stored_data,
  input  logic               alarm_valid,
  input  logic [15:0]        alarm_point,
  input  logic               alarm_kind,
  input  logic [2:0]         new_limit_state,
  input  logic               new_line_fail,
  input  logic [31:0]        record_data,
  input  logic               last_of_run,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [15:0] point;
    logic        kind;
    logic [2:0]  state;
    logic        line_fail;
    logic [31:0] data;
    logic        run_end;
  } alarm_rec_t;

  // shadow of the register file
  logic        scan_on;
  logic [30:0] band;
  int          hi_lim, hihi_lim, lo_lim, lolo_lim, hi_ret, lo_ret;

  alarm_rec_t  expected_alarms[$];
  item_t       seen_word;

  assign seen_word = {point_tag, sample_value, channel_fault, last_value,
                      prior_limit_state, prior_line_fail, stored_data};

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  function automatic void push_alarm(input item_t w, input logic kind,
                                     input logic [2:0] state, input logic cf);
    alarm_rec_t r;
    r.point     = w.point_tag;
    r.kind      = kind;
    r.state     = state;
    r.line_fail = cf;
    r.data      = w.stored_data;
    r.run_end   = 1'b0;
    expected_alarms.push_back(r);
  endfunction

  // work out the run of records one word gives under the current registers
  function automatic void predict_alarms(input item_t w);
    int         v, prev, first;
    longint     diff, mag;
    logic       hi_prior, lo_prior, in_ret, moved;
    alarm_rec_t tail;
    v        = w.sample_value;
    prev     = w.last_value;
    first    = expected_alarms.size();
    hi_prior = (w.prior_limit_state == ST_HI_WARN) || (w.prior_limit_state == ST_HI_ALARM);
    lo_prior = (w.prior_limit_state == ST_LO_WARN) || (w.prior_limit_state == ST_LO_ALARM);
    if (scan_on) begin
      if (w.channel_fault != w.prior_line_fail)
        push_alarm(w, KIND_LINE_FAIL, w.prior_limit_state, w.channel_fault);
      if (!w.channel_fault) begin
        // exact 33-bit change against the stored value
        diff  = longint'(v) - longint'(prev);
        mag   = (diff < 0) ? -diff : diff;
        moved = (band != 0) ? (mag >= longint'(band)) : (mag > 0);
        if (moved) begin
          in_ret = (v >= lo_ret) && (v <= hi_ret);
          if (v >= lo_lim && v <= hi_lim && (hi_prior || lo_prior) &&
              (in_ret || (hi_prior && v < lo_ret) || (lo_prior && v > hi_ret)))
            push_alarm(w, KIND_LIMIT, hi_prior ? ST_HI_RECOVER : ST_LO_RECOVER,
                       w.prior_line_fail);
          if (v > hi_lim && v <= hihi_lim && w.prior_limit_state != ST_HI_WARN)
            push_alarm(w, KIND_LIMIT, ST_HI_WARN, w.prior_line_fail);
          if (v >= hihi_lim && w.prior_limit_state != ST_HI_ALARM)
            push_alarm(w, KIND_LIMIT, ST_HI_ALARM, w.prior_line_fail);
          if (v < lo_lim && v >= lolo_lim && w.prior_limit_state != ST_LO_WARN)
            push_alarm(w, KIND_LIMIT, ST_LO_WARN, w.prior_line_fail);
          if (v < lolo_lim && w.prior_limit_state != ST_LO_ALARM)
            push_alarm(w, KIND_LIMIT, ST_LO_ALARM, w.prior_line_fail);
        end
      end
    end
    // flag the final record of the run
    if (expected_alarms.size() > first) begin
      tail = expected_alarms.pop_back();
      tail.run_end = 1'b1;
      expected_alarms.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    alarm_rec_t  exp_rec;
    logic [31:0] want;
    if (rst) begin
      scan_on  = 1'b0;
      band     = '0;
      hi_lim   = 0;
      hihi_lim = 0;
      lo_lim   = 0;
      lolo_lim = 0;
      hi_ret   = 0;
      lo_ret   = 0;
      expected_alarms.delete();
    end else begin
      // compare each record against the oldest expectation
      if (alarm_valid) begin
        if (expected_alarms.size() == 0) begin
          mismatches++;
          $display("%0t: expected no record, got point %0h kind %0b state %0d",
                   $time, alarm_point, alarm_kind, new_limit_state);
        end else begin
          exp_rec = expected_alarms.pop_front();
          check_field("alarm_point", 32'(exp_rec.point), 32'(alarm_point));
          check_field("alarm_kind", 32'(exp_rec.kind), 32'(alarm_kind));
          check_field("new_limit_state", 32'(exp_rec.state), 32'(new_limit_state));
          check_field("new_line_fail", 32'(exp_rec.line_fail), 32'(new_line_fail));
          check_field("record_data", exp_rec.data, record_data);
          check_field("last_of_run", 32'(exp_rec.run_end), 32'(last_of_run));
        end
      end
      // track register writes, check read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_SCAN_ENABLE:       scan_on  = pwdata[0];
            REG_DEAD_BAND:         band     = pwdata[30:0];
            REG_HIGH_LIMIT:        hi_lim   = pwdata;
            REG_HIGH_HIGH_LIMIT:   hihi_lim = pwdata;
            REG_LOW_LIMIT:         lo_lim   = pwdata;
            REG_LOW_LOW_LIMIT:     lolo_lim = pwdata;
            REG_HIGH_RETURN_LIMIT: hi_ret   = pwdata;
            default:               lo_ret   = pwdata;
          endcase
        end else begin
          case (paddr[ADDR_W-1:2])
            REG_SCAN_ENABLE:       want = {31'b0, scan_on};
            REG_DEAD_BAND:         want = {1'b0, band};
            REG_HIGH_LIMIT:        want = hi_lim;
            REG_HIGH_HIGH_LIMIT:   want = hihi_lim;
            REG_LOW_LIMIT:         want = lo_lim;
            REG_LOW_LOW_LIMIT:     want = lolo_lim;
            REG_HIGH_RETURN_LIMIT: want = hi_ret;
            default:               want = lo_ret;
          endcase
          check_field("prdata", want, prdata);
        end
      end
      if (start && !busy)
        predict_alarms(seen_word);
    end
    outstanding <= expected_alarms.size();
  end

endmodule

### tb/tb_analog_limit_alarm_classifier_core.sv
// Top of the analog limit alarm classifier testbench: clock, reset, register programming,
// directed and random sample words, watchdog and verdict.
// Depends on alc_pkg, the classifier core and alarm_record_checker.
`timescale 1ns / 100ps

module tb_analog_limit_alarm_classifier_core
  import alc_pkg::*;
();

  localparam int Q            = 65536;
  localparam int RANDOM_WORDS = 125;
  localparam int SETTLE       = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MIN_Q        = 32'h80000000;
  localparam int MAX_Q        = 32'h7FFFFFFF;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic [15:0]        point_tag;
  logic signed [31:0] sample_value;
  logic               channel_fault;
  logic signed [31:0] last_value;
  logic [2:0]         prior_limit_state;
  logic               prior_line_fail;
  logic [31:0]        stored_data;
  logic               alarm_valid;
  logic [15:0]        alarm_point;
  logic               alarm_kind;
  logic [2:0]         new_limit_state;
  logic               new_line_fail;
  logic [31:0]        record_data;
  logic               last_of_run;
  int                 mismatches;
  int                 outstanding;
  int                 idle_cycles = 0;

  // register values as last programmed, used to aim the samples
  int shadow [8];

  analog_limit_alarm_classifier_core dut (.*);
  alarm_record_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || alarm_valid || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wr ? value : '0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // drop start and wait until every expected record has come out
  task automatic drain_alarms();
    @(negedge clk);
    start = 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_limits(input logic scan, input logic [30:0] db,
                                input int h, hh, l, ll, hr, lr);
    drain_alarms();
    shadow[REG_SCAN_ENABLE]       = scan;
    shadow[REG_DEAD_BAND]         = db;
    shadow[REG_HIGH_LIMIT]        = h;
    shadow[REG_HIGH_HIGH_LIMIT]   = hh;
    shadow[REG_LOW_LIMIT]         = l;
    shadow[REG_LOW_LOW_LIMIT]     = ll;
    shadow[REG_HIGH_RETURN_LIMIT] = hr;
    shadow[REG_LOW_RETURN_LIMIT]  = lr;
    for (int i = 0; i < $size(shadow); i++) apb_access(1'b1, i[2:0], shadow[i]);
    for (int i = 0; i < $size(shadow); i++) apb_access(1'b0, i[2:0], '0);
  endtask

  task automatic send_word(input item_t w, input int gap);
    @(negedge clk);
    point_tag         = w.point_tag;
    sample_value      = w.sample_value;
    channel_fault     = w.channel_fault;
    last_value        = w.last_value;
    prior_limit_state = w.prior_limit_state;
    prior_line_fail   = w.prior_line_fail;
    stored_data       = w.stored_data;
    start             = 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic item_t make_word(input int s, input int prev, input logic f,
                                      input logic p, input logic [2:0] st);
    item_t w;
    w.point_tag         = 16'($urandom);
    w.sample_value      = s;
    w.channel_fault     = f;
    w.last_value        = prev;
    w.prior_limit_state = st;
    w.prior_line_fail   = p;
    w.stored_data       = $urandom;
    return w;
  endfunction

  // aim samples at the programmed limits, with some extremes and noise
  function automatic item_t random_word();
    int s, prev, db;
    db = shadow[REG_DEAD_BAND];
    case ($urandom_range(0, 9))
      6:       s = MIN_Q;
      7:       s = MAX_Q;
      8, 9:    s = $urandom;
      default: s = shadow[$urandom_range(REG_HIGH_LIMIT, REG_LOW_RETURN_LIMIT)]
                   + int'($urandom_range(0, 4)) - 2;
    endcase
    case ($urandom_range(0, 7))
      0:       prev = s;
      1:       prev = s - db;
      2:       prev = s - db + 1;
      3:       prev = s + db;
      4, 5:    prev = $urandom;
      default: prev = s + int'($urandom_range(0, 6 * Q)) - 3 * Q;
    endcase
    return make_word(s, prev, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                     3'($urandom_range(0, 7)));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int next_step();
    return int'($urandom_range(1, 50)) * Q + int'($urandom_range(0, Q - 1));
  endfunction

  initial begin
    item_t       w;
    int          counted, phase, ll, l, lr, hr, h;
    logic [30:0] db;
    logic        burst;

    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; point_tag = '0; sample_value = '0; channel_fault = 1'b0;
    last_value = '0; prior_limit_state = ST_NORMAL; prior_line_fail = 1'b0; stored_data = '0;
    foreach (shadow[i]) shadow[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // scanning still off after reset: nothing comes out
    send_word(make_word(5 * Q, 0, 1'b1, 1'b0, ST_NORMAL), 0);
    send_word(make_word(90 * Q, 0, 1'b0, 1'b1, ST_HI_WARN), 2);

    // well-ordered limits, any change passes
    program_limits(1'b1, '0, 80 * Q, 100 * Q, 20 * Q, 0, 70 * Q, 30 * Q);
    send_word(make_word(50 * Q, 40 * Q, 1'b1, 1'b0, ST_NORMAL), 0);   // channel fails
    send_word(make_word(50 * Q, 40 * Q, 1'b1, 1'b1, ST_NORMAL), 0);   // still failed
    send_word(make_word(90 * Q, 50 * Q, 1'b0, 1'b1, ST_NORMAL), 0);   // restored, hi warn
    send_word(make_word(90 * Q, 90 * Q, 1'b0, 1'b0, ST_NORMAL), 1);   // no change
    send_word(make_word(90 * Q, 50 * Q, 1'b0, 1'b0, ST_HI_WARN), 0);  // already warned
    send_word(make_word(100 * Q, 50 * Q, 1'b0, 1'b0, ST_NORMAL), 0);  // on the alarm edge
    send_word(make_word(120 * Q, 50 * Q, 1'b0, 1'b0, ST_HI_WARN), 0);
    send_word(make_word(10 * Q, 50 * Q, 1'b0, 1'b0, ST_NORMAL), 3);
    send_word(make_word(-5 * Q, 50 * Q, 1'b0, 1'b0, ST_LO_WARN), 0);
    send_word(make_word(50 * Q, 90 * Q, 1'b0, 1'b0, ST_HI_ALARM), 0); // back into return band
    send_word(make_word(50 * Q, 10 * Q, 1'b0, 1'b0, ST_LO_WARN), 0);
    send_word(make_word(25 * Q, 90 * Q, 1'b0, 1'b0, ST_HI_WARN), 0);  // overshoot below band
    send_word(make_word(75 * Q, 10 * Q, 1'b0, 1'b0, ST_LO_ALARM), 0); // overshoot above band
    send_word(make_word(75 * Q, 90 * Q, 1'b0, 1'b0, ST_HI_WARN), 0);  // not far enough back
    send_word(make_word(90 * Q, 50 * Q, 1'b0, 1'b0, 3'd7), 0);        // unused state code
    send_word(make_word(50 * Q, 40 * Q, 1'b1, 1'b0, 3'd7), 0);
    w = make_word(MAX_Q, MIN_Q, 1'b0, 1'b0, ST_NORMAL);
    w.point_tag = '1;
    w.stored_data = '1;
    send_word(w, 0);
    w = make_word(MIN_Q, MAX_Q, 1'b0, 1'b0, ST_NORMAL);
    w.point_tag = '0;
    w.stored_data = '0;
    send_word(w, 0);

    // widest deadband: only a move of 7FFFFFFF or more passes
    program_limits(1'b1, 31'h7FFFFFFF, 80 * Q, 100 * Q, 20 * Q, 0, 70 * Q, 30 * Q);
    send_word(make_word(MAX_Q, 0, 1'b0, 1'b0, ST_NORMAL), 0);
    send_word(make_word(MAX_Q - 1, 0, 1'b0, 1'b0, ST_NORMAL), 0);

    // crossed limits: several limit records in one run
    program_limits(1'b1, 31'(Q), -10 * Q, 0, 10 * Q, 0, 0, 0);
    send_word(make_word(0, 5 * Q, 1'b0, 1'b1, ST_NORMAL), 0);
    send_word(make_word(0, Q - 1, 1'b0, 1'b0, ST_NORMAL), 0);
    send_word(make_word(0, -Q, 1'b0, 1'b0, ST_HI_WARN), 0);

    // random phases, each under its own register setting
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_WORDS) begin
      case ($urandom_range(0, 4))
        0, 1:    db = '0;
        2:       db = 31'($urandom_range(1, 3) * Q);
        3:       db = 31'($urandom);
        default: db = 31'h7FFFFFFF;
      endcase
      case (phase % 6)
        1:       program_limits(1'b1, db, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom);
        2:       program_limits(1'b0, db, 80 * Q, 100 * Q, 20 * Q, 0, 70 * Q, 30 * Q);
        4:       program_limits(1'b1, db, MAX_Q, MAX_Q, MIN_Q, MIN_Q, MAX_Q, MIN_Q);
        5:       program_limits(1'b1, db, 0, 0, 0, 0, 0, 0);
        default: begin
          ll = (int'($urandom_range(0, 400)) - 200) * Q;
          l  = ll + next_step();
          lr = l + next_step();
          hr = lr + next_step();
          h  = hr + next_step();
          program_limits(1'b1, db, h, h + next_step(), l, ll, hr, lr);
        end
      endcase
      burst = (phase % 4 == 1);
      repeat (25) begin
        send_word(random_word(), burst ? 0 : pick_gap());
        counted++;
      end
      phase++;
    end

    drain_alarms();
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
